FILE: src/i2cstm_pkg.sv
// Package: shared constants and codes for the I2C sensor transaction master.
`timescale 1ns / 1ps

package i2cstm_pkg;

   // request mode codes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_WRITE_ADDRESS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_READ_ADDRESS  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ACK_TIMEOUT   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SETTLE_TICKS  = 2'd3;

   // register reset values
   localparam logic [7:0]  WRITE_ADDRESS_RST = 8'd176;
   localparam logic [7:0]  READ_ADDRESS_RST  = 8'd177;
   localparam logic [7:0]  ACK_TIMEOUT_RST   = 8'd250;
   localparam logic [15:0] SETTLE_TICKS_RST  = 16'd10000;

   // read transaction byte positions
   localparam logic [2:0] CRC_BYTE  = 3'd3;
   localparam logic [2:0] LAST_BYTE = 3'd5;

endpackage

FILE: src/i2cstm_if.sv
// Interfaces: request, response and configuration channels.
`timescale 1ns / 1ps

interface i2cstm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] cmd_first;
   logic [7:0] cmd_second;
   logic       sda_in;

   modport source (output valid, mode, cmd_first, cmd_second, sda_in, input ready);
   modport sink   (input valid, mode, cmd_first, cmd_second, sda_in, output ready);
endinterface

interface i2cstm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl;
   logic        sda_out;
   logic        sda_drive;
   logic        busy_res;
   logic        done_res;
   logic        ack_error;
   logic [31:0] read_word;

   modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, ack_error,
                   read_word, input ready);
   modport sink   (input valid, scl, sda_out, sda_drive, busy_res, done_res, ack_error,
                   read_word, output ready);
endinterface

interface i2cstm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [i2cstm_pkg::CSR_ADDR_W-1:0] addr;
   logic [i2cstm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

FILE: src/i2c_sensor_transaction_master_top.sv
// Top level: I2C sensor transaction master sequencer, one bus tick per request.
//
// Usage:
//   req_ch carries one bus tick per request: mode (tick only, start write,
//   start read), the two write command bytes and the sampled SDA level.
//   rsp_ch returns one response per request: SCL, SDA level and drive enable,
//   busy, done pulse, ack error and the assembled 32-bit read word.
//   csr_ch writes write_address, read_address, ack_timeout and settle_ticks;
//   it is always ready; the user must write it only while the block is idle, as the block does not enforce this.
// Timing:
//   The response is registered and appears in the cycle after its request is
//   taken; a new request is taken every cycle unless rsp_ch stalls. Sequencer
//   state and response register update in one pass. A write sends three bytes with
//   ack polls, a stop and the settle wait; starts are ignored while busy.
// Reset:
//   Sequencer goes idle (SCL high, SDA driven high on its ticks), configuration registers take defaults.
// Backpressure:
//   When rsp_ch stalls, the response register holds and req_ch.ready drops
//   unless the pending response is taken in the same cycle.
`timescale 1ns / 1ps

module i2c_sensor_transaction_master_top (
   input  logic              clock,
   input  logic              reset,
   i2cstm_req_if.sink        req_ch,
   i2cstm_rsp_if.source      rsp_ch,
   i2cstm_csr_if.sink        csr_ch
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_START_HI, PH_START_LO, PH_SB_SET, PH_SB_HIGH, PH_SB_LOW, PH_SB_TAIL,
      PH_WA_LOW, PH_WA_HIGH, PH_WA_POLL, PH_RB_LOW, PH_RB_HIGH, PH_RA_LOW, PH_RA_HIGH,
      PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_SETTLE
   } phase_type;

   // configuration
   logic [7:0]  write_address_ff;
   logic [7:0]  read_address_ff;
   logic [7:0]  ack_timeout_ff;
   logic [15:0] settle_ticks_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic        tick_ff, tick_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] saved_ff, saved_in;
   logic [31:0] word_ff, word_in;
   logic [15:0] wait_ff, wait_in;
   logic        is_read_ff, is_read_in;
   logic        failed_ff, failed_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        scl_ff, scl_in;
   logic        sda_out_ff, sda_out_in;
   logic        sda_drive_ff, sda_drive_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        ack_error_ff, ack_error_in;

   logic        req_accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.scl       = scl_ff;
   assign rsp_ch.sda_out   = sda_out_ff;
   assign rsp_ch.sda_drive = sda_drive_ff;
   assign rsp_ch.busy_res  = busy_ff;
   assign rsp_ch.done_res  = done_ff;
   assign rsp_ch.ack_error = ack_error_ff;
   assign rsp_ch.read_word = word_ff;

   // one bus tick of the sequencer
   always_comb begin
      phase_type ph;
      logic      half;

      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_count_in  = bit_count_ff;
      byte_index_in = byte_index_ff;
      shift_in      = shift_ff;
      saved_in      = saved_ff;
      word_in       = word_ff;
      wait_in       = wait_ff;
      is_read_in    = is_read_ff;
      failed_in     = failed_ff;
      scl_in        = 1'b1;
      sda_out_in    = 1'b1;
      sda_drive_in  = 1'b1;
      done_in       = 1'b0;
      ack_error_in  = 1'b0;

      if (phase_ff == PH_IDLE &&
          (req_ch.mode == i2cstm_pkg::MODE_WRITE || req_ch.mode == i2cstm_pkg::MODE_READ)) begin
         is_read_in    = (req_ch.mode == i2cstm_pkg::MODE_READ);
         failed_in     = 1'b0;
         saved_in      = {req_ch.cmd_first, req_ch.cmd_second};
         byte_index_in = 3'd0;
         bit_count_in  = 4'd0;
         shift_in      = (req_ch.mode == i2cstm_pkg::MODE_READ) ? read_address_ff
                                                                : write_address_ff;
         phase_in      = PH_START_HI;
         tick_in       = 1'b0;
      end

      ph      = phase_in;
      half    = tick_in;
      busy_in = (ph != PH_IDLE);
      // two-tick phases: toggle, cleared again on phase change
      tick_in = ~tick_in;

      case (ph)
         PH_IDLE: begin
            tick_in = tick_ff;
         end
         PH_START_HI: begin
            if (half) phase_in = PH_START_LO;
         end
         PH_START_LO: begin
            sda_out_in = 1'b0;
            if (half) phase_in = PH_SB_SET;
         end
         PH_SB_SET: begin
            scl_in     = 1'b0;
            sda_out_in = shift_in[7];
            if (half) phase_in = PH_SB_HIGH;
         end
         PH_SB_HIGH: begin
            sda_out_in = shift_in[7];
            if (half) phase_in = PH_SB_LOW;
         end
         PH_SB_LOW: begin
            scl_in     = 1'b0;
            sda_out_in = shift_in[7];
            if (half) begin
               shift_in     = {shift_in[6:0], shift_in[7]};
               bit_count_in = bit_count_in + 4'd1;
               phase_in     = (bit_count_in >= 4'd8) ? PH_SB_TAIL : PH_SB_SET;
            end
         end
         PH_SB_TAIL: begin
            scl_in     = 1'b0;
            sda_out_in = shift_in[0];
            if (half) begin
               wait_in  = 16'd0;
               phase_in = PH_WA_LOW;
            end
         end
         PH_WA_LOW: begin
            scl_in       = 1'b0;
            sda_drive_in = 1'b0;
            tick_in      = 1'b0;
            phase_in     = PH_WA_HIGH;
         end
         PH_WA_HIGH: begin
            sda_drive_in = 1'b0;
            tick_in      = 1'b0;
            phase_in     = PH_WA_POLL;
         end
         PH_WA_POLL: begin
            sda_drive_in = 1'b0;
            tick_in      = 1'b0;
            if (!req_ch.sda_in) begin
               bit_count_in = 4'd0;
               if (is_read_in) begin
                  byte_index_in = 3'd1;
                  shift_in      = 8'd0;
                  phase_in      = PH_RB_LOW;
               end else if (byte_index_in == 3'd0) begin
                  byte_index_in = 3'd1;
                  shift_in      = saved_in[15:8];
                  phase_in      = PH_SB_SET;
               end else if (byte_index_in == 3'd1) begin
                  byte_index_in = 3'd2;
                  shift_in      = saved_in[7:0];
                  phase_in      = PH_SB_SET;
               end else begin
                  phase_in = PH_STOP_A;
               end
            end else begin
               wait_in = wait_in + 16'd1;
               if (wait_in > {8'd0, ack_timeout_ff}) begin
                  failed_in = 1'b1;
                  phase_in  = PH_STOP_A;
               end
            end
         end
         PH_RB_LOW: begin
            scl_in       = 1'b0;
            sda_drive_in = 1'b0;
            if (half) phase_in = PH_RB_HIGH;
         end
         PH_RB_HIGH: begin
            sda_drive_in = 1'b0;
            if (!half) shift_in = {shift_in[6:0], req_ch.sda_in};
            if (half) begin
               bit_count_in = bit_count_in + 4'd1;
               phase_in     = (bit_count_in >= 4'd8) ? PH_RA_LOW : PH_RB_LOW;
            end
         end
         PH_RA_LOW: begin
            scl_in     = 1'b0;
            sda_out_in = (byte_index_in >= i2cstm_pkg::LAST_BYTE);
            if (half) phase_in = PH_RA_HIGH;
         end
         PH_RA_HIGH: begin
            sda_out_in = (byte_index_in >= i2cstm_pkg::LAST_BYTE);
            if (half) begin
               if (byte_index_in != i2cstm_pkg::CRC_BYTE) word_in = {word_in[23:0], shift_in};
               if (byte_index_in >= i2cstm_pkg::LAST_BYTE) begin
                  phase_in = PH_STOP_A;
               end else begin
                  byte_index_in = byte_index_in + 3'd1;
                  bit_count_in  = 4'd0;
                  shift_in      = 8'd0;
                  phase_in      = PH_RB_LOW;
               end
            end
         end
         PH_STOP_A: begin
            scl_in     = 1'b0;
            sda_out_in = 1'b0;
            if (half) phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            sda_out_in = 1'b0;
            if (half) phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            if (half) begin
               done_in      = 1'b1;
               ack_error_in = failed_in;
               wait_in      = 16'd0;
               if (!is_read_in && !failed_in && settle_ticks_ff != 16'd0) phase_in = PH_SETTLE;
               else phase_in = PH_IDLE;
            end
         end
         PH_SETTLE: begin
            tick_in = 1'b0;
            wait_in = wait_in + 16'd1;
            if (wait_in >= settle_ticks_ff) phase_in = PH_IDLE;
         end
         default: begin
            tick_in  = 1'b0;
            phase_in = PH_IDLE;
         end
      endcase

      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_address_ff <= i2cstm_pkg::WRITE_ADDRESS_RST;
         read_address_ff  <= i2cstm_pkg::READ_ADDRESS_RST;
         ack_timeout_ff   <= i2cstm_pkg::ACK_TIMEOUT_RST;
         settle_ticks_ff  <= i2cstm_pkg::SETTLE_TICKS_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            i2cstm_pkg::REG_WRITE_ADDRESS: write_address_ff <= csr_ch.data[7:0];
            i2cstm_pkg::REG_READ_ADDRESS:  read_address_ff  <= csr_ch.data[7:0];
            i2cstm_pkg::REG_ACK_TIMEOUT:   ack_timeout_ff   <= csr_ch.data[7:0];
            i2cstm_pkg::REG_SETTLE_TICKS:  settle_ticks_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= 1'b0;
         bit_count_ff  <= 4'd0;
         byte_index_ff <= 3'd0;
         shift_ff      <= 8'd0;
         saved_ff      <= 16'd0;
         word_ff       <= 32'd0;
         wait_ff       <= 16'd0;
         is_read_ff    <= 1'b0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff      <= phase_in;
            tick_ff       <= tick_in;
            bit_count_ff  <= bit_count_in;
            byte_index_ff <= byte_index_in;
            shift_ff      <= shift_in;
            saved_ff      <= saved_in;
            word_ff       <= word_in;
            wait_ff       <= wait_in;
            is_read_ff    <= is_read_in;
            failed_ff     <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_ff       <= scl_in;
         sda_out_ff   <= sda_out_in;
         sda_drive_ff <= sda_drive_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         ack_error_ff <= ack_error_in;
      end
   end

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> busy_ff)
      else $error("done reported outside a transaction");

   a_error_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ack_error_ff |-> done_ff)
      else $error("ack error without done");

   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !sda_drive_ff |-> busy_ff)
      else $error("SDA released while idle");

endmodule
